### rtl/core/hystach_pkg.sv
// hystach_pkg: shared types and constants for the hysteresis tachometer core
// used by hystach_detect, hystach_divider and hysteresis_tachometer_rpm_core
`timescale 1ns / 1ps
`default_nettype none

package hystach_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT = 12;
   localparam int TIME_WIDTH_DEFAULT   = 32;

   localparam int RPM_WIDTH    = 26;
   localparam int PERIOD_WIDTH = 32;
   localparam logic [RPM_WIDTH-1:0] RPM_NUMERATOR = RPM_WIDTH'(60000000);

   localparam int LOW_THRESHOLD_RESET  = 2000;
   localparam int HIGH_THRESHOLD_RESET = 3500;

   // configuration register indexes
   localparam int CSR_ADDR_WIDTH = 2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_LOW_THRESHOLD  = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_HIGH_THRESHOLD = 2'd1;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // divider status seen by the top level
   typedef struct packed {
      logic idle;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

### rtl/core/hysteresis_tachometer_rpm_core.sv
// hysteresis_tachometer_rpm_core: top level of the hysteresis tachometer
// instantiates hystach_detect and hystach_divider, depends on hystach_pkg
//
// Usage:
//   req_ carries one ADC sample and its microsecond timestamp; a transfer
//   happens when req_valid is high and req_stall is low.
//   A sample below low_threshold arms the detector; a sample above
//   high_threshold while armed is a rising edge and produces one rsp_
//   transfer with rsp_period_us (time since the previous edge, wrapping)
//   and rsp_rpm = 60000000 / period, saturated to 60000000 at zero period.
//   Other samples produce nothing.
//   An edge sample starts the bit-serial divider, one of 26 quotient bits per
//   cycle; the finished quotient then moves into the output register when it
//   has room, and req_stall stays high after the edge transfer until the
//   divider hands its result over, so no sample is taken while it works.
//   The output register holds one result while the divider works on the next
//   edge; while rsp_stall is high and that register is full, a finished
//   quotient waits in the divider and req_stall stays high.
//   csr_ writes set the thresholds (index 0 low, 1 high); others are ignored.
//   Reset (synchronous, active high) restores thresholds 2000 and 3500,
//   disarms the detector and sets the previous edge time to 0.
`timescale 1ns / 1ps
`default_nettype none

module hysteresis_tachometer_rpm_core #(
   parameter int SAMPLE_WIDTH = hystach_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int TIME_WIDTH   = hystach_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [hystach_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic [SAMPLE_WIDTH-1:0]                csr_wdata,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [SAMPLE_WIDTH-1:0]                req_sample,
   input  wire logic [TIME_WIDTH-1:0]                  req_time_us,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [hystach_pkg::RPM_WIDTH-1:0]           rsp_rpm,
   output logic [hystach_pkg::PERIOD_WIDTH-1:0]        rsp_period_us
);
   import hystach_pkg::*;

   div_status_type          div_status;
   logic                    accept;
   logic                    edge_start;
   logic [TIME_WIDTH-1:0]   elapsed;
   logic                    take;
   logic [RPM_WIDTH-1:0]    div_rpm;
   logic [PERIOD_WIDTH-1:0] div_period;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RPM_WIDTH-1:0]    rsp_rpm_ff, rsp_rpm_in;
   logic [PERIOD_WIDTH-1:0] rsp_period_ff, rsp_period_in;

   assign req_stall = !div_status.idle;
   assign accept    = req_valid && !req_stall;
   // move a finished quotient into the output register when it has room
   assign take      = div_status.done && (!rsp_valid_ff || !rsp_stall);

   hystach_detect #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .TIME_WIDTH   (TIME_WIDTH)
   ) u_detect (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .sample     (req_sample),
      .time_us    (req_time_us),
      .edge_start (edge_start),
      .elapsed    (elapsed)
   );

   hystach_divider #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (edge_start),
      .elapsed (elapsed),
      .take    (take),
      .status  (div_status),
      .rpm     (div_rpm),
      .period  (div_period)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_rpm_in    = rsp_rpm_ff;
      rsp_period_in = rsp_period_ff;
      if (take) begin
         rsp_valid_in  = 1'b1;
         rsp_rpm_in    = div_rpm;
         rsp_period_in = div_period;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rpm_ff    <= rsp_rpm_in;
      rsp_period_ff <= rsp_period_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rpm       = rsp_rpm_ff;
   assign rsp_period_us = rsp_period_ff;

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (div_status.done && rsp_valid_ff && rsp_stall) |=> div_status.done)
      else $error("finished result dropped while output full");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      take |=> (rsp_valid_ff && rsp_rpm_ff == $past(div_rpm)))
      else $error("output register not loaded on take");

   a_edge_when_idle: assert property (@(posedge clock) disable iff (reset)
      edge_start |-> div_status.idle)
      else $error("edge detected while divider busy");

endmodule

`default_nettype wire

### rtl/core/hystach_detect.sv
// hystach_detect: threshold registers, armed flag and last edge timestamp
// depends on hystach_pkg
`timescale 1ns / 1ps
`default_nettype none

module hystach_detect #(
   parameter int SAMPLE_WIDTH = 12,
   parameter int TIME_WIDTH   = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [hystach_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic [SAMPLE_WIDTH-1:0]               csr_wdata,
   input  wire logic                                  accept,
   input  wire logic [SAMPLE_WIDTH-1:0]               sample,
   input  wire logic [TIME_WIDTH-1:0]                 time_us,
   output logic                                       edge_start,
   output logic [TIME_WIDTH-1:0]                      elapsed
);
   import hystach_pkg::*;

   logic [SAMPLE_WIDTH-1:0] low_ff, low_in;
   logic [SAMPLE_WIDTH-1:0] high_ff, high_in;
   logic                    armed_ff, armed_in;
   logic [TIME_WIDTH-1:0]   last_edge_ff, last_edge_in;
   logic                    below_low;

   assign below_low  = sample < low_ff;
   assign edge_start = accept && armed_ff && (sample > high_ff);
   // wraps modulo 2^TIME_WIDTH
   assign elapsed    = time_us - last_edge_ff;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_LOW_THRESHOLD:  low_in  = csr_wdata;
            CSR_HIGH_THRESHOLD: high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      armed_in     = armed_ff;
      last_edge_in = last_edge_ff;
      if (edge_start) begin
         armed_in     = 1'b0;
         last_edge_in = time_us;
      end
      // edge test first, then the arm test may rearm in the same transfer
      if (accept && below_low) begin
         armed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= SAMPLE_WIDTH'(LOW_THRESHOLD_RESET);
         high_ff      <= SAMPLE_WIDTH'(HIGH_THRESHOLD_RESET);
         armed_ff     <= 1'b0;
         last_edge_ff <= '0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         armed_ff     <= armed_in;
         last_edge_ff <= last_edge_in;
      end
   end

   a_edge_disarms: assert property (@(posedge clock) disable iff (reset)
      (edge_start && !below_low) |=> !armed_ff)
      else $error("edge did not disarm detector");

   a_edge_time: assert property (@(posedge clock) disable iff (reset)
      edge_start |=> (last_edge_ff == $past(time_us)))
      else $error("edge timestamp not captured");

   a_low_arms: assert property (@(posedge clock) disable iff (reset)
      (accept && below_low) |=> armed_ff)
      else $error("low sample did not arm detector");

endmodule

`default_nettype wire

### rtl/core/hystach_divider.sv
// hystach_divider: bit-serial restoring divider, constant numerator over period
// depends on hystach_pkg
`timescale 1ns / 1ps
`default_nettype none

module hystach_divider #(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [TIME_WIDTH-1:0]                elapsed,
   input  wire logic                                 take,
   output hystach_pkg::div_status_type               status,
   output logic [hystach_pkg::RPM_WIDTH-1:0]         rpm,
   output logic [hystach_pkg::PERIOD_WIDTH-1:0]      period
);
   import hystach_pkg::*;

   localparam int CNT_W   = $clog2(RPM_WIDTH);
   localparam int EXT_W   = (TIME_WIDTH > RPM_WIDTH) ? TIME_WIDTH : RPM_WIDTH;
   localparam int PEXT_W  = (TIME_WIDTH > PERIOD_WIDTH) ? TIME_WIDTH : PERIOD_WIDTH;

   div_state_type state_ff, state_in;

   logic [RPM_WIDTH-1:0]    div_ff, div_in;
   logic                    big_ff, big_in;
   logic                    zero_ff, zero_in;
   logic [RPM_WIDTH-1:0]    num_ff, num_in;
   logic [RPM_WIDTH-1:0]    rem_ff, rem_in;
   logic [RPM_WIDTH-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PERIOD_WIDTH-1:0] period_ff, period_in;

   logic [EXT_W-1:0]        elapsed_ext;
   logic [PEXT_W-1:0]       elapsed_pext;
   logic [RPM_WIDTH:0]      partial;
   logic [RPM_WIDTH:0]      diff;
   logic                    fits;

   assign elapsed_ext  = EXT_W'(elapsed);
   assign elapsed_pext = PEXT_W'(elapsed);

   // one quotient bit per cycle, numerator bits shift in from the top
   assign partial = {rem_ff, num_ff[RPM_WIDTH-1]};
   assign diff    = partial - {1'b0, div_ff};
   assign fits    = !big_ff && (partial >= {1'b0, div_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: if (start) state_in = DIV_RUN;
         DIV_RUN:  if (count_ff == '0) state_in = DIV_DONE;
         DIV_DONE: if (take) state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      div_in    = div_ff;
      big_in    = big_ff;
      zero_in   = zero_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      count_in  = count_ff;
      period_in = period_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               div_in    = elapsed_ext[RPM_WIDTH-1:0];
               big_in    = |(elapsed_ext >> RPM_WIDTH);
               zero_in   = (elapsed == '0);
               num_in    = RPM_NUMERATOR;
               rem_in    = '0;
               quo_in    = '0;
               count_in  = CNT_W'(RPM_WIDTH - 1);
               period_in = elapsed_pext[PERIOD_WIDTH-1:0];
            end
         end
         DIV_RUN: begin
            rem_in   = fits ? diff[RPM_WIDTH-1:0] : partial[RPM_WIDTH-1:0];
            num_in   = {num_ff[RPM_WIDTH-2:0], 1'b0};
            quo_in   = {quo_ff[RPM_WIDTH-2:0], fits};
            count_in = count_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      status.idle = (state_ff == DIV_IDLE);
      status.done = (state_ff == DIV_DONE);
      // a zero period saturates
      rpm         = zero_ff ? RPM_NUMERATOR : quo_ff;
      period      = period_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff    <= div_in;
      big_ff    <= big_in;
      zero_ff   <= zero_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      count_ff  <= count_in;
      period_ff <= period_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == DIV_IDLE))
      else $error("divider started while busy");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == DIV_IDLE) |-> ##(RPM_WIDTH + 1) (state_ff == DIV_DONE))
      else $error("divider latency wrong");

   a_quotient: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_DONE && !zero_ff && !big_ff) |->
         ((64'(quo_ff) * 64'(div_ff) <= 64'(RPM_NUMERATOR)) &&
          (64'(RPM_NUMERATOR) - 64'(quo_ff) * 64'(div_ff) < 64'(div_ff))))
      else $error("divider quotient wrong");

   a_big_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_DONE && big_ff) |-> (quo_ff == '0))
      else $error("long period gave nonzero quotient");

endmodule

`default_nettype wire
